// ===== sv/tbsl_pkg.sv =====
// shared constants and types for the token bucket send limiter
package tbsl_pkg;

  localparam int RATE_W     = 40;  // 16.24 fixed point rate
  localparam int CEIL_W     = 36;  // whole bytes
  localparam int BUDGET_W   = 52;  // 36.16 fixed point bytes
  localparam int FRAC_BITS  = 16;
  localparam int RATE_EXTRA = 8;   // rate has this many more fraction bits than budget
  localparam int WAIT_W     = 32;
  localparam int ACC_W      = 61;  // product accumulator, top bit flags overflow
  localparam int ALU_W      = 62;
  localparam int REM_W      = RATE_W + 1;
  localparam int CFG_IDX_W  = 1;

  typedef logic [BUDGET_W-1:0]  budget_t;
  typedef logic [RATE_W-1:0]    rate_t;
  typedef logic [CEIL_W-1:0]    ceil_t;
  typedef logic [WAIT_W-1:0]    wait_t;
  typedef logic [ACC_W-1:0]     acc_t;
  typedef logic [ALU_W-1:0]     alu_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_RATE = 1'b0;
  localparam cfg_idx_t REG_CEIL = 1'b1;

  localparam budget_t BUDGET_MAX = '1;
  localparam wait_t   WAIT_MAX   = '1;
  // product at or above this saturates the budget
  localparam acc_t    OVF_LIM    = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ===== sv/token_bucket_send_limiter_top.sv =====
// token bucket send limiter: shared add/sub unit under a small sequencer
// sequence: a zero rate goes straight to staging an allow; else the 40-step multiply (if time has
//   elapsed since an earlier request), add and compare, and on refusal a 44-step divide and rounding
// flow: one transaction in flight; the next is taken the cycle after the result is staged,
//   and staging waits while the output register is held by out_stall
// reset: synchronous active-low rst_n clears registers, budget, previous timestamp and started flag
module token_bucket_send_limiter_top #(
  parameter int TIME_BITS   = 48,
  parameter int LENGTH_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TIME_BITS-1:0]      in_now_time,
  input  logic [LENGTH_BITS-1:0]    in_send_bytes,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_allowed,
  output logic [tbsl_pkg::WAIT_W-1:0] out_wait_ticks,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  tbsl_pkg::cfg_idx_t        cfg_index,
  input  logic [tbsl_pkg::RATE_W-1:0] cfg_wdata
);
  import tbsl_pkg::*;

  localparam int NEED_W = LENGTH_BITS + FRAC_BITS;
  localparam int Q_W    = NEED_W + RATE_EXTRA;
  localparam int SHF_W  = (Q_W > RATE_W) ? Q_W : RATE_W;
  localparam int CNT_W  = $clog2(SHF_W);
  localparam int EXT_W  = (TIME_BITS > ACC_W) ? TIME_BITS : ACC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]           state_r, state_nxt;
  rate_t                rate_r, rate_nxt;
  ceil_t                ceil_r, ceil_nxt;
  budget_t              budget_r, budget_nxt;
  logic [TIME_BITS-1:0] prev_stamp_r, prev_stamp_nxt;
  logic                 started_r, started_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  acc_t                 wrk_r, wrk_nxt;
  logic                 ovf_r, ovf_nxt;
  acc_t                 mul_e_r, mul_e_nxt;
  logic [SHF_W-1:0]     shf_r, shf_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 res_allowed_r, res_allowed_nxt;
  wait_t                res_wait_r, res_wait_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_allowed_r, out_allowed_nxt;
  wait_t                out_wait_r, out_wait_nxt;

  // shared adder/subtractor
  alu_t alu_a, alu_b, alu_y;
  logic alu_sub;
  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  logic                 in_take;
  logic                 out_free;
  logic [TIME_BITS-1:0] elapsed;
  logic [EXT_W-1:0]     elapsed_ext;
  acc_t                 elapsed_clamp;
  logic [NEED_W-1:0]    need_in;
  budget_t              inc;
  logic [BUDGET_W:0]    sum;
  budget_t              diff;
  budget_t              cap;
  logic [NEED_W-1:0]    shortfall;
  logic [Q_W-1:0]       num;
  logic [REM_W-1:0]     rem_sh;
  logic [Q_W:0]         q_round;

  assign in_stall       = (state_r != S_IDLE);
  assign in_take        = in_valid && !in_stall;
  assign out_free       = !out_valid_r || !out_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_allowed    = out_allowed_r;
  assign out_wait_ticks = out_wait_r;

  assign elapsed       = (in_now_time >= prev_stamp_r) ? (in_now_time - prev_stamp_r) : '0;
  assign elapsed_ext   = EXT_W'(elapsed);
  assign elapsed_clamp = (elapsed_ext >= EXT_W'(OVF_LIM)) ? OVF_LIM
                                                          : elapsed_ext[ACC_W-1:0];
  assign need_in       = {in_send_bytes, {FRAC_BITS{1'b0}}};
  assign inc           = ovf_r ? BUDGET_MAX : wrk_r[ACC_W-2:RATE_EXTRA];
  assign sum           = {1'b0, budget_r} + {1'b0, inc};
  assign diff          = budget_r - BUDGET_W'(need_r);
  assign cap           = {ceil_r, {FRAC_BITS{1'b0}}};
  assign shortfall     = need_r - budget_r[NEED_W-1:0];
  assign num           = {shortfall, {RATE_EXTRA{1'b0}}};
  assign rem_sh        = {wrk_r[REM_W-2:0], shf_r[SHF_W-1]};
  assign q_round       = {1'b0, shf_r[Q_W-1:0]} + (Q_W+1)'(wrk_r != '0);

  always_comb begin
    state_nxt       = state_r;
    rate_nxt        = rate_r;
    ceil_nxt        = ceil_r;
    budget_nxt      = budget_r;
    prev_stamp_nxt  = prev_stamp_r;
    started_nxt     = started_r;
    need_nxt        = need_r;
    wrk_nxt         = wrk_r;
    ovf_nxt         = ovf_r;
    mul_e_nxt       = mul_e_r;
    shf_nxt         = shf_r;
    cnt_nxt         = cnt_r;
    res_allowed_nxt = res_allowed_r;
    res_wait_nxt    = res_wait_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_allowed_nxt = out_allowed_r;
    out_wait_nxt    = out_wait_r;
    alu_a           = '0;
    alu_b           = '0;
    alu_sub         = 1'b0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RATE: rate_nxt = cfg_wdata;
        REG_CEIL: ceil_nxt = cfg_wdata[CEIL_W-1:0];
        default:  rate_nxt = rate_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          need_nxt = need_in;
          wrk_nxt  = '0;
          ovf_nxt  = 1'b0;
          if (rate_r == '0) begin
            res_allowed_nxt = 1'b1;
            res_wait_nxt    = '0;
            state_nxt       = S_DONE;
          end else begin
            prev_stamp_nxt = in_now_time;
            if (!started_r) begin
              // first request credits its own length through the add step
              started_nxt = 1'b1;
              wrk_nxt     = ACC_W'({need_in, {RATE_EXTRA{1'b0}}});
              state_nxt   = S_ADD;
            end else if (elapsed == '0) begin
              state_nxt = S_ADD;
            end else begin
              mul_e_nxt = elapsed_clamp;
              shf_nxt   = SHF_W'(rate_r) << (SHF_W - RATE_W);
              cnt_nxt   = CNT_W'(RATE_W - 1);
              state_nxt = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        // msb-first shift-add over the rate bits, overflow is sticky
        alu_a   = ALU_W'({wrk_r, 1'b0});
        alu_b   = shf_r[SHF_W-1] ? ALU_W'(mul_e_r) : '0;
        wrk_nxt = alu_y[ACC_W-1:0];
        ovf_nxt = ovf_r || alu_y[ALU_W-1] || alu_y[ALU_W-2];
        shf_nxt = shf_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        budget_nxt = sum[BUDGET_W] ? BUDGET_MAX : sum[BUDGET_W-1:0];
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (budget_r >= BUDGET_W'(need_r)) begin
          budget_nxt      = (diff > cap) ? cap : diff;
          res_allowed_nxt = 1'b1;
          res_wait_nxt    = '0;
          state_nxt       = S_DONE;
        end else begin
          wrk_nxt   = '0;
          shf_nxt   = SHF_W'(num) << (SHF_W - Q_W);
          cnt_nxt   = CNT_W'(Q_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, quotient bits shift in at the bottom
        alu_a   = ALU_W'(rem_sh);
        alu_b   = ALU_W'(rate_r);
        alu_sub = 1'b1;
        if (alu_y[ALU_W-1]) begin
          wrk_nxt = ACC_W'(rem_sh);
          shf_nxt = {shf_r[SHF_W-2:0], 1'b0};
        end else begin
          wrk_nxt = ACC_W'(alu_y[REM_W-1:0]);
          shf_nxt = {shf_r[SHF_W-2:0], 1'b1};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_allowed_nxt = 1'b0;
        res_wait_nxt    = (q_round > (Q_W+1)'(WAIT_MAX)) ? WAIT_MAX : q_round[WAIT_W-1:0];
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_allowed_r;
          out_wait_nxt    = res_wait_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rate_r       <= '0;
      ceil_r       <= '0;
      budget_r     <= '0;
      prev_stamp_r <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rate_r       <= rate_nxt;
      ceil_r       <= ceil_nxt;
      budget_r     <= budget_nxt;
      prev_stamp_r <= prev_stamp_nxt;
      started_r    <= started_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r        <= need_nxt;
    wrk_r         <= wrk_nxt;
    ovf_r         <= ovf_nxt;
    mul_e_r       <= mul_e_nxt;
    shf_r         <= shf_nxt;
    cnt_r         <= cnt_nxt;
    res_allowed_r <= res_allowed_nxt;
    res_wait_r    <= res_wait_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_wait_r    <= out_wait_nxt;
  end

  // a granted send never leaves more than the ceiling
  a_cap_after_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && budget_r >= BUDGET_W'(need_r)) |=> (budget_r <= cap))
    else $error("budget above ceiling after grant");

  // zero rate bypasses the arithmetic and allows
  a_zero_rate_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && rate_r == '0) |=> (state_r == S_DONE && res_allowed_r))
    else $error("zero rate did not bypass");

  // a refusal always asks for a nonzero wait
  a_refuse_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (!res_allowed_r && res_wait_r != '0))
    else $error("refusal with zero wait");

  // divide remainder stays below the rate
  a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (wrk_r < ACC_W'(rate_r)))
    else $error("divide remainder out of range");

  // a result appears only out of the staging state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside staging state");

endmodule

// ===== test/token_bucket_send_limiter_top_tb.sv =====
// self-checking testbench for the token bucket send limiter: predictor, scoreboard and drivers
`timescale 1ns / 100ps

module token_bucket_send_limiter_top_tb;
  import tbsl_pkg::*;

  localparam int TIME_W       = 48;
  localparam int LEN_W        = 20;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 167;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [95:0] PROD_LIM = (96'd1 << 60) - 96'd1;

  typedef struct {
    logic  allowed;
    wait_t wait_ticks;
  } verdict_t;

  // keeps the bucket state and the verdicts still owed by the block
  class send_verdict_board;
    rate_t             rate;
    ceil_t             ceiling;
    budget_t           budget;
    logic [TIME_W-1:0] prev_stamp;
    bit                started;
    verdict_t          owed[$];
    int                errors;

    function new();
      rate = '0;
      ceiling = '0;
      budget = '0;
      prev_stamp = '0;
      started = 1'b0;
      errors = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [RATE_W-1:0] data);
      case (idx)
        REG_RATE: rate = data;
        REG_CEIL: ceiling = data[CEIL_W-1:0];
        default: ;
      endcase
    endfunction

    function budget_t credit(budget_t base, logic [63:0] add);
      logic [63:0] sum;
      sum = 64'(base) + add;
      return (sum > 64'(BUDGET_MAX)) ? BUDGET_MAX : sum[BUDGET_W-1:0];
    endfunction

    function void note_request(logic [TIME_W-1:0] now, logic [LEN_W-1:0] len);
      logic [63:0] need;
      logic [63:0] elapsed;
      logic [95:0] prod;
      logic [63:0] shortfall;
      logic [63:0] quot;
      verdict_t    v;
      need = 64'(len) << FRAC_BITS;
      v.allowed = 1'b1;
      v.wait_ticks = '0;
      if (rate != '0) begin
        elapsed = '0;
        if (!started) begin
          // first request pays for itself
          started = 1'b1;
          budget = credit(budget, need);
        end else if (now >= prev_stamp) begin
          elapsed = 64'(now) - 64'(prev_stamp);
        end
        prev_stamp = now;
        prod = 96'(elapsed) * 96'(rate);
        if (prod > PROD_LIM) budget = BUDGET_MAX;
        else budget = credit(budget, 64'(prod >> RATE_EXTRA));
        if (64'(budget) >= need) begin
          budget = budget - need[BUDGET_W-1:0];
          if (budget > {ceiling, {FRAC_BITS{1'b0}}}) budget = {ceiling, {FRAC_BITS{1'b0}}};
        end else begin
          shortfall = (need - 64'(budget)) << RATE_EXTRA;
          quot = shortfall / 64'(rate);
          if (shortfall % 64'(rate) != 0) quot = quot + 1;
          v.allowed = 1'b0;
          v.wait_ticks = (quot > 64'(WAIT_MAX)) ? WAIT_MAX : quot[WAIT_W-1:0];
        end
      end
      owed.push_back(v);
    endfunction

    function void check_verdict(logic allowed, wait_t wait_ticks);
      verdict_t v;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result allowed=%0d wait_ticks=%0d", $time, allowed,
                 wait_ticks);
        errors++;
        return;
      end
      v = owed.pop_front();
      if (allowed !== v.allowed) begin
        $display("%0t: allowed mismatch expected %0d actual %0d", $time, v.allowed, allowed);
        errors++;
      end
      if (wait_ticks !== v.wait_ticks) begin
        $display("%0t: wait_ticks mismatch expected %0d actual %0d", $time, v.wait_ticks,
                 wait_ticks);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [TIME_W-1:0]   in_now_time;
  logic [LEN_W-1:0]    in_send_bytes;
  logic                out_valid;
  logic                out_stall;
  logic                out_allowed;
  logic [WAIT_W-1:0]   out_wait_ticks;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_idx_t            cfg_index;
  logic [RATE_W-1:0]   cfg_wdata;

  send_verdict_board   verdicts;
  int                  send_idle_pct;
  int                  stall_pct;
  int                  quiet_cycles;
  logic [TIME_W-1:0]   cur_time;
  rate_t               cur_rate;

  token_bucket_send_limiter_top #(
    .TIME_BITS   (TIME_W),
    .LENGTH_BITS (LEN_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_time    (in_now_time),
    .in_send_bytes  (in_send_bytes),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_allowed    (out_allowed),
    .out_wait_ticks (out_wait_ticks),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) verdicts.set_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) verdicts.note_request(in_now_time, in_send_bytes);
      if (out_valid && !out_stall) verdicts.check_verdict(out_allowed, out_wait_ticks);
    end
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(input logic [TIME_W-1:0] now, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_now_time   <= now;
    in_send_bytes <= len;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [RATE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // settle the block before touching its registers
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (verdicts.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setting(input rate_t rate, input logic [RATE_W-1:0] ceil_word);
    drain();
    write_reg(REG_RATE, rate);
    write_reg(REG_CEIL, ceil_word);
    cur_rate = rate;
  endtask

  initial begin
    logic [63:0] span;
    logic [RATE_W-1:0] ceil_word;
    rate_t rate;
    int pick;
    logic [LEN_W-1:0] len;

    verdicts      = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_now_time   = '0;
    in_send_bytes = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_RATE;
    cfg_wdata     = '0;
    cur_time      = '0;
    cur_rate      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: limiting off after reset
    send_request(48'd5, 20'd77);

    load_setting(rate_t'(1) << 24, 40'd1000);
    send_request(48'd100, 20'd500);                  // first request credits itself
    send_request(48'd100, 20'd0);
    send_request(48'd150, 20'd100);                  // refusal
    send_request(48'd140, 20'd10);                   // time going backwards
    send_request(48'hFFFF_FFFF_FFFF, 20'hFFFFF);     // credit saturates, capped
    send_request(48'd0, 20'hFFFFF);
    send_request(48'd1, 20'd1000);

    load_setting(rate_t'(1), 40'd0);
    send_request(48'd10, 20'hFFFFF);                 // wait saturates
    send_request(48'hFFFF_FFFF_FFFF, 20'd1);
    send_request(48'hFFFF_FFFF_FFFF, 20'd0);

    load_setting('1, 40'(CEIL_W'('1)));
    send_request(48'hAAAA_AAAA_AAAA, 20'h55555);
    send_request(48'hAAAA_AAAA_AAAB, 20'hAAAAA);
    send_request(48'h5555_5555_5555, 20'hFFFFF);
    send_request(48'h5555_5555_5556, 20'hFFFFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin rate = rate_t'(1) << 24; ceil_word = 40'd4096; end
        1: begin rate = '0; ceil_word = 40'({$urandom, $urandom}) & 40'hF_FFFF_FFFF; end
        2: begin rate = rate_t'(1); ceil_word = 40'd0; end
        3: begin rate = '1; ceil_word = 40'(CEIL_W'('1)); end
        4: begin rate = rate_t'({$urandom, $urandom}); ceil_word = 40'({$urandom, $urandom}); end
        5: begin rate = rate_t'(1) << 20; ceil_word = 40'd100000; end
        6: begin rate = rate_t'(3) << 23; ceil_word = 40'd1 << 20; end
        default: begin
          rate = rate_t'($urandom_range(1 << 26, 1));
          ceil_word = 40'($urandom_range(65535));
        end
      endcase
      load_setting(rate, ceil_word);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase

      // time step that buys about two kilobytes at this rate
      if (cur_rate == '0) span = 64'd4096;
      else span = (64'd2048 << 24) / 64'(cur_rate);
      if (span < 64'd1) span = 64'd1;
      if (span > 64'h8000_0000) span = 64'h8000_0000;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          len = LEN_W'($urandom_range(2047));
          cur_time = cur_time + TIME_W'($urandom_range(span[31:0]));
        end else if (pick < 88) begin
          len = LEN_W'($urandom);
          cur_time = cur_time + TIME_W'($urandom);
        end else if (pick < 94) begin
          len = LEN_W'($urandom_range(2047));
          cur_time = cur_time - TIME_W'($urandom_range(5000));
        end else begin
          len = LEN_W'($urandom);
          cur_time = TIME_W'({$urandom, $urandom});
        end
        send_request(cur_time, len);
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (verdicts.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (verdicts.errors == 0 && verdicts.owed.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== token_bucket_send_limiter_top.f =====
sv/tbsl_pkg.sv
sv/token_bucket_send_limiter_top.sv
test/token_bucket_send_limiter_top_tb.sv
